/* rtl/cis_pkg.sv */
// Package for the codec power-up sequencer: word types, state and
// configuration structs, and the mode, request and phase codes.
// No dependencies.
package cis_pkg;

   localparam int CsrIndexWidth = 2;
   localparam int CsrDataWidth  = 8;

   localparam logic [CsrIndexWidth-1:0] CSR_REGISTER_COUNT    = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_MIN_BOARD_VERSION = 2'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_LOCK_MASK         = 2'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_RETRY_LIMIT       = 2'd3;

   localparam logic [7:0] RESET_REGISTER_COUNT    = 8'd26;
   localparam logic [7:0] RESET_MIN_BOARD_VERSION = 8'd1;
   localparam logic [7:0] RESET_LOCK_MASK         = 8'd1;
   localparam logic [7:0] RESET_RETRY_LIMIT       = 8'd10;

   localparam logic [7:0] FAIL_COUNT_MAX = 8'd255;

   localparam logic [1:0] MODE_START = 2'd0;
   localparam logic [1:0] MODE_TICK  = 2'd1;
   localparam logic [1:0] MODE_DONE  = 2'd2;

   localparam logic [1:0] REQ_NONE  = 2'd0;
   localparam logic [1:0] REQ_WRITE = 2'd1;
   localparam logic [1:0] REQ_POWER = 2'd2;
   localparam logic [1:0] REQ_PLL   = 2'd3;

   localparam logic [2:0] PH_IDLE    = 3'd0;
   localparam logic [2:0] PH_BOARD   = 3'd1;
   localparam logic [2:0] PH_WRITE   = 3'd2;
   localparam logic [2:0] PH_WRITE_W = 3'd3;
   localparam logic [2:0] PH_POWER   = 3'd4;
   localparam logic [2:0] PH_POWER_W = 3'd5;
   localparam logic [2:0] PH_PLL     = 3'd6;
   localparam logic [2:0] PH_PLL_W   = 3'd7;

   typedef struct packed {
      logic [1:0] mode;
      logic       version_valid;
      logic [7:0] board_version;
      logic       bus_ready;
      logic       transfer_ok;
      logic       data_valid;
      logic [7:0] read_byte;
   } cis_req_type;

   typedef struct packed {
      logic [1:0] request;
      logic [7:0] table_index;
      logic [2:0] phase;
      logic       hw_fault;
   } cis_rsp_type;

   typedef struct packed {
      logic [7:0] register_count;
      logic [7:0] min_board_version;
      logic [7:0] lock_mask;
      logic [7:0] retry_limit;
   } cis_cfg_type;

   typedef struct packed {
      logic       started;
      logic [2:0] phase;
      logic [7:0] write_index;
      logic [7:0] fail_count;
   } cis_state_type;

endpackage

/* rtl/cis_csr.sv */
// Configuration registers of the codec power-up sequencer.
// Depends on cis_pkg for the register indexes, reset values and cis_cfg_type.
module cis_csr
   import cis_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_write,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_data,
   output cis_cfg_type              cfg
);

   cis_cfg_type cfg_ff;
   cis_cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_REGISTER_COUNT:    cfg_in.register_count    = csr_data;
            CSR_MIN_BOARD_VERSION: cfg_in.min_board_version = csr_data;
            CSR_LOCK_MASK:         cfg_in.lock_mask         = csr_data;
            CSR_RETRY_LIMIT:       cfg_in.retry_limit       = csr_data;
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.register_count    <= RESET_REGISTER_COUNT;
         cfg_ff.min_board_version <= RESET_MIN_BOARD_VERSION;
         cfg_ff.lock_mask         <= RESET_LOCK_MASK;
         cfg_ff.retry_limit       <= RESET_RETRY_LIMIT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* rtl/cis_step.sv */
// Next-state and result logic of the codec power-up sequencer for one word.
// Depends on cis_pkg for the codes and the word, state and configuration types.
module cis_step
   import cis_pkg::*;
(
   input  cis_req_type   word,
   input  cis_state_type state,
   input  cis_cfg_type   cfg,
   output cis_state_type state_next,
   output cis_rsp_type   result
);

   logic [7:0] fail_next;

   always_comb begin
      state_next         = state;
      result.request     = REQ_NONE;
      result.table_index = 8'd0;
      result.hw_fault    = 1'b0;

      if (word.transfer_ok) begin
         fail_next = 8'd0;
      end else if (state.fail_count != FAIL_COUNT_MAX) begin
         fail_next = 8'(state.fail_count + 8'd1);
      end else begin
         fail_next = state.fail_count;
      end

      unique case (word.mode)
         MODE_START: begin
            state_next.started     = 1'b1;
            state_next.phase       = PH_BOARD;
            state_next.write_index = 8'd0;
         end
         MODE_TICK: begin
            if (state.started) begin
               unique case (state.phase)
                  PH_BOARD: begin
                     if (word.version_valid) begin
                        if (word.board_version > cfg.min_board_version) begin
                           state_next.phase       = PH_WRITE;
                           state_next.write_index = 8'd0;
                        end else begin
                           state_next.phase = PH_IDLE;
                        end
                     end
                  end
                  PH_WRITE: begin
                     if (state.write_index < cfg.register_count) begin
                        if (word.bus_ready) begin
                           result.request     = REQ_WRITE;
                           result.table_index = state.write_index;
                           state_next.phase   = PH_WRITE_W;
                        end
                     end else begin
                        state_next.phase = PH_POWER;
                     end
                  end
                  PH_POWER: begin
                     if (word.bus_ready) begin
                        result.request   = REQ_POWER;
                        state_next.phase = PH_POWER_W;
                     end
                  end
                  PH_PLL: begin
                     if (word.bus_ready) begin
                        result.request   = REQ_PLL;
                        state_next.phase = PH_PLL_W;
                     end
                  end
                  default: state_next.phase = state.phase;
               endcase
            end
         end
         MODE_DONE: begin
            state_next.fail_count = fail_next;
            if (fail_next >= cfg.retry_limit) begin
               state_next.phase = PH_IDLE;
               result.hw_fault  = 1'b1;
            end else begin
               unique case (state.phase)
                  PH_WRITE_W: begin
                     if (word.transfer_ok) begin
                        state_next.write_index = 8'(state.write_index + 8'd1);
                     end
                     state_next.phase = PH_WRITE;
                  end
                  PH_POWER_W: begin
                     state_next.phase = word.transfer_ok ? PH_PLL : PH_POWER;
                  end
                  PH_PLL_W: begin
                     if (word.transfer_ok && word.data_valid &&
                         ((word.read_byte & cfg.lock_mask) != 8'd0)) begin
                        state_next.phase = PH_IDLE;
                     end else begin
                        state_next.phase = PH_PLL;
                     end
                  end
                  default: state_next.phase = state.phase;
               endcase
            end
         end
         default: state_next = state;
      endcase

      result.phase = state_next.phase;
   end

endmodule

/* rtl/codec_init_sequencer_top.sv */
// Top level of the codec power-up sequencer: input register, step logic,
// sequencer state and result register. Depends on cis_pkg, cis_csr, cis_step.

// Each word (start, tick or bus completion) yields exactly one result word
// with the request to issue, the table index, the new phase and a fault flag.
// A word is held in the input register and then handled, when the sequencer
// state and the result register are updated together, so one word per cycle
// is sustained while the result register is not stalled.
// A word is held back only while the result register is full and stalled.
// Configuration registers are written through the csr_ port; the user must write them
// only while no word is in flight, which the block itself does not enforce.
module codec_init_sequencer_top
   import cis_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  cis_req_type              req_word,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output cis_rsp_type              rsp_word,
   input  logic                     csr_write,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_data
);

   cis_cfg_type   cfg;
   cis_state_type state_ff;
   cis_state_type state_in;
   cis_req_type   in_word_ff;
   logic          in_valid_ff;
   cis_rsp_type   rsp_word_ff;
   cis_rsp_type   rsp_word_in;
   logic          rsp_valid_ff;
   logic          advance;
   logic          handle;

   cis_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   cis_step u_step (
      .word       (in_word_ff),
      .state      (state_ff),
      .cfg        (cfg),
      .state_next (state_in),
      .result     (rsp_word_in)
   );

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign handle    = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         if (!req_stall) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= in_valid_ff;
         end
         if (handle) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         in_word_ff <= req_word;
      end
      if (handle) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

`ifndef ASSERT_OFF
   a_fault_idle : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_word_ff.hw_fault |-> rsp_word_ff.phase == PH_IDLE)
      else $error("fault result does not report the idle phase");

   a_request_wait : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_word_ff.request != REQ_NONE |->
         rsp_word_ff.phase == PH_WRITE_W || rsp_word_ff.phase == PH_POWER_W ||
         rsp_word_ff.phase == PH_PLL_W)
      else $error("request issued without entering a wait phase");

   a_phase_tracks_state : assert property (@(posedge clock) disable iff (reset)
      handle |=> rsp_valid_ff && rsp_word_ff.phase == state_ff.phase)
      else $error("result phase differs from the sequencer state");

   a_index_only_on_write : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_word_ff.request != REQ_WRITE |->
         rsp_word_ff.table_index == 8'd0)
      else $error("table index set without a table write");
`endif

endmodule

/* tb/sv/codec_init_sequencer_top_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for codec_init_sequencer_top: directed and random words
// checked against a predictor of the power-up sequence, under several settings.
// Depends on cis_pkg and the RTL of codec_init_sequencer_top.

module codec_init_sequencer_top_tb;
   import cis_pkg::*;

   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam int QUIET_LIMIT = 1000;
   localparam int ReqBits = $bits(cis_req_type);

   class power_seq_scoreboard;
      cis_cfg_type   cfg;
      cis_state_type st;
      cis_rsp_type   rsp_due[$];
      int            mismatch_total;

      function new();
         cfg = '{RESET_REGISTER_COUNT, RESET_MIN_BOARD_VERSION, RESET_LOCK_MASK,
                 RESET_RETRY_LIMIT};
         st = '0;
         mismatch_total = 0;
      endfunction

      function void set_reg(logic [CsrIndexWidth-1:0] idx, logic [CsrDataWidth-1:0] v);
         case (idx)
            CSR_REGISTER_COUNT:    cfg.register_count = v;
            CSR_MIN_BOARD_VERSION: cfg.min_board_version = v;
            CSR_LOCK_MASK:         cfg.lock_mask = v;
            CSR_RETRY_LIMIT:       cfg.retry_limit = v;
            default: ;
         endcase
      endfunction

      function cis_rsp_type sequence_step(cis_req_type w);
         cis_rsp_type r;
         r = '0;
         case (w.mode)
            MODE_START: begin
               st.started = 1'b1;
               st.phase = PH_BOARD;
               st.write_index = '0;
            end
            MODE_TICK: begin
               if (st.started) begin
                  case (st.phase)
                     PH_BOARD: begin
                        if (w.version_valid) begin
                           if (w.board_version > cfg.min_board_version) begin
                              st.phase = PH_WRITE;
                              st.write_index = '0;
                           end else begin
                              st.phase = PH_IDLE;
                           end
                        end
                     end
                     PH_WRITE: begin
                        if (st.write_index < cfg.register_count) begin
                           if (w.bus_ready) begin
                              r.request = REQ_WRITE;
                              r.table_index = st.write_index;
                              st.phase = PH_WRITE_W;
                           end
                        end else begin
                           st.phase = PH_POWER;
                        end
                     end
                     PH_POWER: begin
                        if (w.bus_ready) begin
                           r.request = REQ_POWER;
                           st.phase = PH_POWER_W;
                        end
                     end
                     PH_PLL: begin
                        if (w.bus_ready) begin
                           r.request = REQ_PLL;
                           st.phase = PH_PLL_W;
                        end
                     end
                     default: ;
                  endcase
               end
            end
            MODE_DONE: begin
               if (w.transfer_ok) begin
                  st.fail_count = '0;
               end else if (st.fail_count != FAIL_COUNT_MAX) begin
                  st.fail_count = st.fail_count + 8'd1;
               end
               if (st.fail_count >= cfg.retry_limit) begin
                  st.phase = PH_IDLE;
                  r.hw_fault = 1'b1;
               end else begin
                  case (st.phase)
                     PH_WRITE_W: begin
                        if (w.transfer_ok) begin
                           st.write_index = st.write_index + 8'd1;
                        end
                        st.phase = PH_WRITE;
                     end
                     PH_POWER_W: begin
                        st.phase = w.transfer_ok ? PH_PLL : PH_POWER;
                     end
                     PH_PLL_W: begin
                        if (w.transfer_ok && w.data_valid &&
                            (w.read_byte & cfg.lock_mask) != 8'd0) begin
                           st.phase = PH_IDLE;
                        end else begin
                           st.phase = PH_PLL;
                        end
                     end
                     default: ;
                  endcase
               end
            end
            default: ;
         endcase
         r.phase = st.phase;
         return r;
      endfunction

      function void note_req(cis_req_type w);
         rsp_due.push_back(sequence_step(w));
      endfunction

      function void check_rsp(cis_rsp_type got);
         cis_rsp_type want;
         if (rsp_due.size() == 0) begin
            mismatch_total++;
            if (mismatch_total <= 10) begin
               $display("ERROR: unexpected result word: %s %0d index %0d phase %0d fault %0d",
                        "request", got.request, got.table_index, got.phase,
                        got.hw_fault);
            end
            return;
         end
         want = rsp_due.pop_front();
         if (got.request !== want.request || got.table_index !== want.table_index ||
             got.phase !== want.phase || got.hw_fault !== want.hw_fault) begin
            mismatch_total++;
            if (mismatch_total <= 10) begin
               $display("ERROR: result word mismatch at %0t", $realtime);
               $display("   expected request %0d index %0d phase %0d fault %0d",
                        want.request, want.table_index, want.phase, want.hw_fault);
               $display("   actual   request %0d index %0d phase %0d fault %0d",
                        got.request, got.table_index, got.phase, got.hw_fault);
            end
         end
      endfunction
   endclass

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   cis_req_type              req_word = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   cis_rsp_type              rsp_word;
   logic                     csr_write = 1'b0;
   logic [CsrIndexWidth-1:0] csr_index = '0;
   logic [CsrDataWidth-1:0]  csr_data = '0;

   power_seq_scoreboard sb;
   bit req_steady = 1'b0;
   bit rsp_steady = 1'b0;
   int stall_run = 0;
   int quiet_cycles = 0;

   codec_init_sequencer_top uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int hold_len();
      if ($urandom_range(0, 9) < 8) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   function automatic cis_req_type mk(logic [1:0] m, logic vv, logic [7:0] ver, logic rdy,
                                      logic ok, logic dv, logic [7:0] rb);
      cis_req_type w;
      w = '{m, vv, ver, rdy, ok, dv, rb};
      return w;
   endfunction

   // Most words follow the predicted phase so that sequences run deep; the
   // rest are noise, including the unused mode.
   function automatic cis_req_type next_word();
      cis_req_type w;
      int r;
      int lo;
      w = ReqBits'($urandom);
      r = $urandom_range(0, 99);
      lo = int'(sb.cfg.min_board_version);
      if (r < 2) begin
         w.mode = MODE_UNUSED;
         return w;
      end
      if (r < 12) begin
         case ($urandom_range(0, 2))
            0: w.mode = MODE_START;
            1: w.mode = MODE_TICK;
            default: w.mode = MODE_DONE;
         endcase
         return w;
      end
      if (!sb.st.started) begin
         w.mode = MODE_START;
         return w;
      end
      case (sb.st.phase)
         PH_BOARD: begin
            w.mode = MODE_TICK;
            w.version_valid = ($urandom_range(0, 7) != 0);
            if (lo != 255 && $urandom_range(0, 9) != 0) begin
               w.board_version = 8'($urandom_range(lo + 1, 255));
            end else begin
               w.board_version = 8'($urandom_range(0, lo));
            end
         end
         PH_WRITE, PH_POWER, PH_PLL: begin
            w.mode = MODE_TICK;
            w.bus_ready = ($urandom_range(0, 6) != 0);
         end
         PH_WRITE_W, PH_POWER_W: begin
            w.mode = MODE_DONE;
            w.transfer_ok = ($urandom_range(0, 11) != 0);
         end
         PH_PLL_W: begin
            w.mode = MODE_DONE;
            w.transfer_ok = ($urandom_range(0, 11) != 0);
            w.data_valid = ($urandom_range(0, 7) != 0);
            if ($urandom_range(0, 2) == 0) begin
               w.read_byte = w.read_byte | sb.cfg.lock_mask;
            end else begin
               w.read_byte = w.read_byte & ~sb.cfg.lock_mask;
            end
         end
         default: begin
            w.mode = MODE_START;
         end
      endcase
      return w;
   endfunction

   task automatic send_word(cis_req_type w);
      int gap;
      if ($urandom_range(0, 79) == 0) begin
         req_steady = !req_steady;
      end
      gap = (req_steady || $urandom_range(0, 99) < 65) ? 0 : hold_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_req(w);
   endtask

   task automatic settle();
      while (sb.rsp_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic load_config(cis_cfg_type c);
      logic [CsrDataWidth-1:0] vals [4];
      logic [CsrIndexWidth-1:0] idx;
      vals[CSR_REGISTER_COUNT] = c.register_count;
      vals[CSR_MIN_BOARD_VERSION] = c.min_board_version;
      vals[CSR_LOCK_MASK] = c.lock_mask;
      vals[CSR_RETRY_LIMIT] = c.retry_limit;
      for (int i = 0; i < 4; i++) begin
         idx = CsrIndexWidth'(i);
         csr_write <= 1'b1;
         csr_index <= idx;
         csr_data <= vals[idx];
         @(posedge clock);
         sb.set_reg(idx, vals[idx]);
      end
      csr_write <= 1'b0;
   endtask

   task automatic run_phase(cis_cfg_type c, int count);
      load_config(c);
      repeat (count) send_word(next_word());
      req_valid <= 1'b0;
      settle();
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.check_rsp(rsp_word);
      end
      if ($urandom_range(0, 99) == 0) begin
         rsp_steady = !rsp_steady;
      end
      if (stall_run > 0) begin
         stall_run = stall_run - 1;
         rsp_stall <= 1'b1;
      end else if (rsp_steady || $urandom_range(0, 99) < 75) begin
         rsp_stall <= 1'b0;
      end else begin
         stall_run = hold_len() - 1;
         rsp_stall <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("** codec_init_sequencer_top: FAILED **");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      sb = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // A one-entry table lets the directed words walk the whole sequence.
      load_config('{8'd1, 8'd0, 8'h80, 8'd3});
      send_word(mk(MODE_UNUSED, 1'b1, 8'hFF, 1'b1, 1'b1, 1'b1, 8'hFF));
      send_word(mk(MODE_TICK, 1'b1, 8'hFF, 1'b1, 1'b0, 1'b0, 8'h00));
      send_word(mk(MODE_DONE, 1'b0, 8'h00, 1'b0, 1'b0, 1'b1, 8'hFF));
      send_word(mk(MODE_START, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00));
      send_word(mk(MODE_TICK, 1'b0, 8'hFF, 1'b1, 1'b0, 1'b0, 8'h00));
      send_word(mk(MODE_TICK, 1'b1, 8'h00, 1'b1, 1'b0, 1'b0, 8'h00));
      send_word(mk(MODE_TICK, 1'b1, 8'hFF, 1'b1, 1'b0, 1'b0, 8'h00));
      send_word(mk(MODE_START, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00));
      send_word(mk(MODE_TICK, 1'b1, 8'hFF, 1'b1, 1'b0, 1'b0, 8'h00));
      send_word(mk(MODE_TICK, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00));
      send_word(mk(MODE_TICK, 1'b0, 8'h00, 1'b1, 1'b0, 1'b0, 8'h00));
      send_word(mk(MODE_UNUSED, 1'b0, 8'h00, 1'b1, 1'b0, 1'b0, 8'h00));
      send_word(mk(MODE_DONE, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00));
      send_word(mk(MODE_TICK, 1'b0, 8'h00, 1'b1, 1'b0, 1'b0, 8'h00));
      send_word(mk(MODE_DONE, 1'b0, 8'h00, 1'b0, 1'b1, 1'b0, 8'h00));
      send_word(mk(MODE_TICK, 1'b0, 8'h00, 1'b1, 1'b0, 1'b0, 8'h00));
      send_word(mk(MODE_TICK, 1'b0, 8'h00, 1'b1, 1'b0, 1'b0, 8'h00));
      send_word(mk(MODE_DONE, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00));
      send_word(mk(MODE_TICK, 1'b0, 8'h00, 1'b1, 1'b0, 1'b0, 8'h00));
      send_word(mk(MODE_DONE, 1'b0, 8'h00, 1'b0, 1'b1, 1'b0, 8'h00));
      send_word(mk(MODE_TICK, 1'b0, 8'h00, 1'b1, 1'b0, 1'b0, 8'h00));
      send_word(mk(MODE_DONE, 1'b0, 8'h00, 1'b0, 1'b1, 1'b0, 8'hFF));
      send_word(mk(MODE_TICK, 1'b0, 8'h00, 1'b1, 1'b0, 1'b0, 8'h00));
      send_word(mk(MODE_DONE, 1'b0, 8'h00, 1'b0, 1'b1, 1'b1, 8'h7F));
      send_word(mk(MODE_TICK, 1'b0, 8'h00, 1'b1, 1'b0, 1'b0, 8'h00));
      send_word(mk(MODE_DONE, 1'b0, 8'h00, 1'b0, 1'b0, 1'b1, 8'h80));
      send_word(mk(MODE_DONE, 1'b0, 8'h00, 1'b0, 1'b0, 1'b1, 8'h80));
      send_word(mk(MODE_DONE, 1'b0, 8'h00, 1'b0, 1'b0, 1'b1, 8'h80));
      req_valid <= 1'b0;
      settle();

      run_phase('{8'd26, 8'd1, 8'd1, 8'd10}, 480);
      run_phase('{8'd0, 8'd0, 8'hFF, 8'd1}, 250);
      run_phase('{8'd5, 8'hFF, 8'd1, 8'hFF}, 120);
      run_phase('{8'd3, 8'd254, 8'd0, 8'd2}, 200);
      run_phase('{8'hFF, 8'd0, 8'h80, 8'hFF}, 700);
      run_phase('{8'($urandom_range(0, 6)), 8'($urandom_range(0, 3)),
                  8'($urandom_range(0, 255)), 8'($urandom_range(1, 4))}, 180);

      repeat (8) @(posedge clock);
      if (sb.mismatch_total == 0 && sb.rsp_due.size() == 0) begin
         $display("** codec_init_sequencer_top: PASSED **");
      end else begin
         $display("** codec_init_sequencer_top: FAILED **");
      end
      $finish;
   end

endmodule
